>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked implication checks with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> src/sps_pkg.sv
// ---------------------------------------------------------------------------
// sps_pkg
// Shared widths, constants and types of the 1-D sandpile column sweep.
// ---------------------------------------------------------------------------
package sps_pkg;

  localparam int unsigned COLUMNS = 128;
  localparam int unsigned IDX_W   = $clog2(COLUMNS);
  localparam int unsigned H_W     = 16;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned COL_W   = 7;

  localparam logic [15:0] LFSR_MASK      = 16'hB400;
  localparam logic [15:0] NOISE_SEED_RST = 16'd1;
  localparam logic [7:0]  GRAIN_PER_RST  = 8'd4;
  localparam logic [15:0] HEIGHT_LIM_RST = 16'd50;

  // Configuration register indexes
  localparam logic [1:0] REG_GRAIN_PERIOD = 2'd0;
  localparam logic [1:0] REG_HEIGHT_LIMIT = 2'd1;
  localparam logic [1:0] REG_NOISE_SEED   = 2'd2;

  // Command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_TAIL,
    ST_EMIT
  } state_e;

  // One column-pair relaxation step
  typedef struct packed {
    logic           moved;
    logic [H_W-1:0] new_a;
    logic [H_W-1:0] new_b;
  } xfer_t;

endpackage

>>> src/sandpile_column_sweep_core.sv
// Flow: a read beat goes from idle to the emit state, which loads the output
//   register; a tick sweeps column pairs through the height memory, writes the
//   tail column, then emits; a tick that finds column 0 at the limit emits at once.
// Items: one at a time; a tick is a read-modify-write sweep over the height memory;
//   the emit state waits while the output still holds an untaken result.
// Reset: asynchronous, active low; heights read as zero, tick phase zero,
//   noise generator at seed 1, registers at their defaults; no clearing pass.
// ---------------------------------------------------------------------------
// sandpile_column_sweep_core
// One-dimensional sandpile automaton with a column-by-column relaxation sweep
// over a height memory.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sandpile_column_sweep_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [6:0] column, [7] zero
  input  logic        s_axis_tuser_i,  // [0] cmd
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // [15:0] height, [22:16] transfers, [23] stopped
);
  import sps_pkg::*;

  localparam logic [IDX_W-1:0] LAST_K    = IDX_W'(COLUMNS - 3);
  localparam logic [IDX_W-1:0] TAIL_ADDR = IDX_W'(COLUMNS - 2);
  localparam logic [IDX_W-1:0] ADDR_ONE  = IDX_W'(1);

  state_e state_q, state_d;

  logic [7:0]       grain_q;
  logic [15:0]      limit_q;
  logic [7:0]       phase_q;
  logic [H_W-1:0]   h0_q;
  logic [H_W-1:0]   a_q;
  logic [IDX_W-1:0] k_q;
  logic [CNT_W-1:0] count_q;
  logic             is_read_q, col0_q, oob_q;
  logic             m_valid_q;
  logic [23:0]      m_data_q;

  logic             accept, load_out, step_en, seed_load;
  logic             stopped_now;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [H_W-1:0]   mem_wdata, mem_rdata;
  logic [IDX_W-1:0] col_idx;
  logic [8:0]       phase_next;
  logic [H_W-1:0]   h0_inc;
  logic [H_W-1:0]   read_height;
  xfer_t            xfer;

  assign col_idx     = IDX_W'(s_axis_tdata_i[COL_W-1:0]);
  assign stopped_now = h0_q >= limit_q;
  assign accept      = s_axis_tvalid_i && s_axis_tready_o;
  assign seed_load   = cfg_we_i && (cfg_idx_i == REG_NOISE_SEED);
  assign phase_next  = {1'b0, phase_q} + 9'd1;
  assign h0_inc      = (phase_next >= {1'b0, grain_q} && h0_q != 16'hFFFF) ?
                       h0_q + 16'd1 : h0_q;

  sps_heights_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sps_xfer_unit u_xfer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_load_i (seed_load),
    .seed_i      (cfg_data_i),
    .step_i      (step_en),
    .a_i         (a_q),
    .b_i         (mem_rdata),
    .xfer_o      (xfer)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser_i == CMD_READ || stopped_now) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_SWEEP;
          end
        end
      end
      ST_SWEEP: begin
        if (k_q == LAST_K) begin
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: state_d = ST_EMIT;
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    mem_re          = 1'b0;
    mem_raddr       = k_q + IDX_W'(2);
    mem_we          = 1'b0;
    mem_waddr       = k_q;
    mem_wdata       = xfer.new_a;
    step_en         = 1'b0;
    load_out        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        mem_re          = s_axis_tvalid_i;
        mem_raddr       = (s_axis_tuser_i == CMD_READ) ? col_idx : ADDR_ONE;
      end
      ST_SWEEP: begin
        mem_re  = 1'b1;
        mem_we  = 1'b1;
        step_en = 1'b1;
      end
      ST_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = TAIL_ADDR;
        mem_wdata = a_q;
      end
      ST_EMIT: load_out = !m_valid_q || m_axis_tready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      grain_q <= GRAIN_PER_RST;
      limit_q <= HEIGHT_LIM_RST;
      phase_q <= '0;
      h0_q    <= '0;
      k_q     <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_GRAIN_PERIOD: grain_q <= cfg_data_i[7:0];
          REG_HEIGHT_LIMIT: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        k_q     <= '0;
        count_q <= '0;
        if (s_axis_tuser_i == CMD_TICK && !stopped_now) begin
          phase_q <= (phase_next >= {1'b0, grain_q}) ? 8'd0 : phase_next[7:0];
          h0_q    <= h0_inc;
        end
      end
      if (step_en) begin
        k_q <= k_q + IDX_W'(1);
        if (xfer.moved && count_q != {CNT_W{1'b1}}) begin
          count_q <= count_q + CNT_W'(1);
        end
        // keep column 0 mirrored for the stop check
        if (k_q == '0) begin
          h0_q <= xfer.new_a;
        end
      end
    end
  end

  // Carried height of the current column; no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q       <= h0_inc;
      is_read_q <= s_axis_tuser_i == CMD_READ;
      col0_q    <= s_axis_tdata_i[COL_W-1:0] == '0;
      oob_q     <= 32'(s_axis_tdata_i[COL_W-1:0]) >= COLUMNS;
    end else if (step_en) begin
      a_q <= xfer.new_b;
    end
  end

  always_comb begin
    if (oob_q) begin
      read_height = '0;
    end else if (col0_q) begin
      read_height = h0_q;
    end else begin
      read_height = mem_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {stopped_now, count_q, is_read_q ? read_height : h0_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `ASSERT_IMPLIES(a_k_range, clk_i, rst_ni, state_q == ST_SWEEP, k_q <= LAST_K)
  `ASSERT_IMPLIES(a_rw_apart, clk_i, rst_ni, mem_we && mem_re, mem_waddr != mem_raddr)
  `ASSERT_IMPLIES(a_count_bound, clk_i, rst_ni, state_q == ST_SWEEP, 32'(count_q) <= 32'(k_q))
  `ASSERT_NEXT(a_tail_emit, clk_i, rst_ni, state_q == ST_TAIL, state_q == ST_EMIT)

endmodule

>>> src/sps_heights_ram.sv
// ---------------------------------------------------------------------------
// sps_heights_ram
// Column height store: one write and one registered read port, with
// per-entry valid bits so unwritten columns read as zero after reset.
// ---------------------------------------------------------------------------
module sps_heights_ram (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [sps_pkg::IDX_W-1:0] waddr_i,
  input  logic [sps_pkg::H_W-1:0]   wdata_i,
  input  logic                      re_i,
  input  logic [sps_pkg::IDX_W-1:0] raddr_i,
  output logic [sps_pkg::H_W-1:0]   rdata_o
);
  import sps_pkg::*;

  logic [H_W-1:0]     mem [COLUMNS];
  logic [COLUMNS-1:0] valid_q;
  logic [H_W-1:0]     rdata_q;
  logic               rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

>>> src/sps_xfer_unit.sv
// ---------------------------------------------------------------------------
// sps_xfer_unit
// Noise generator and grain transfer between one column and its right
// neighbor.
// ---------------------------------------------------------------------------
module sps_xfer_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    seed_load_i,
  input  logic [15:0]             seed_i,
  input  logic                    step_i,
  input  logic [sps_pkg::H_W-1:0] a_i,
  input  logic [sps_pkg::H_W-1:0] b_i,
  output sps_pkg::xfer_t          xfer_o
);
  import sps_pkg::*;

  logic [15:0]    lfsr_q, lfsr_d;
  logic [15:0]    lfsr_adv;
  logic [H_W-1:0] diff;
  logic [16:0]    span;
  logic [32:0]    prod;
  logic [H_W-1:0] ng;
  logic           moved;

  // Galois step, shifted right
  assign lfsr_adv = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? LFSR_MASK : 16'h0000);

  assign moved = {1'b0, a_i} >= ({1'b0, b_i} + 17'd2);
  assign diff  = a_i - b_i;
  assign span  = {1'b0, diff} + 17'd2;
  assign prod  = {16'h0000, span} * {17'h00000, lfsr_adv};
  assign ng    = prod[32:17] + 16'd1;

  always_comb begin
    xfer_o.moved = moved;
    xfer_o.new_a = moved ? (a_i - ng) : a_i;
    xfer_o.new_b = moved ? (b_i + ng) : b_i;
  end

  always_comb begin
    lfsr_d = lfsr_q;
    if (seed_load_i) begin
      lfsr_d = seed_i;
    end else if (step_i && moved) begin
      lfsr_d = lfsr_adv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= NOISE_SEED_RST;
    end else begin
      lfsr_q <= lfsr_d;
    end
  end

endmodule
